// ----- hw/rtl/ape_pkg.sv -----
// Shared types, constants and small helpers for the Arrhenius property evaluator.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package ape_pkg;

    // Fixed-point formats.
    localparam int FRAC_BITS      = 24;
    localparam int TEMP_FRAC_BITS = 16;
    localparam int ACT_FRAC       = 12;
    localparam int LOG_FRAC       = 30;

    // Constants in fixed point.
    localparam logic [27:0] LN2_Q28   = 28'd186065279;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    // Activation quotient: Tact * 2^DIV_SHIFT / T, capped at 2^CAP_LOG.
    localparam int DIV_SHIFT = TEMP_FRAC_BITS + FRAC_BITS - ACT_FRAC;
    localparam int CAP_LOG   = 40;
    localparam int QUOT_BITS = CAP_LOG + 1;

    // Width of the power term n*ln(T).
    localparam int NT_W = 42;

    localparam int EXP_TERMS = 12;

    // Pipeline depths of the back-end units.
    localparam int POW_LAT   = LOG_FRAC + 5;
    localparam int DIV_LAT   = QUOT_BITS + 1;
    localparam int EXP_LAT   = 3 * EXP_TERMS + 4;
    localparam int TOTAL_LAT = DIV_LAT + 1 + EXP_LAT;

    typedef enum logic [1:0] {
        REG_LOG_PREFACTOR   = 2'd0,
        REG_TEMP_EXPONENT   = 2'd1,
        REG_ACTIVATION_TEMP = 2'd2,
        REG_VISCOSITY_MODE  = 2'd3
    } cfg_reg_t;

    // One queued item from the front end.
    typedef struct packed {
        logic        vld;
        logic        zero;
        logic [31:0] temp;
    } ape_item_t;

    // Reciprocal floor(2^32 / k) for the Taylor series divisions.
    function automatic logic [32:0] recip(input int k);
        logic [32:0] r;
        case (k)
            1:       r = 33'h1_0000_0000;
            2:       r = 33'd2147483648;
            3:       r = 33'd1431655765;
            4:       r = 33'd1073741824;
            5:       r = 33'd858993459;
            6:       r = 33'd715827882;
            7:       r = 33'd613566756;
            8:       r = 33'd536870912;
            9:       r = 33'd477218588;
            10:      r = 33'd429496729;
            11:      r = 33'd390451572;
            12:      r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ape_front.sv -----
// Front end: accepts temperature samples, flags zero temperature, queues them.
// Depends on ape_pkg.
`default_nettype none

module ape_front
    import ape_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] temperature,
    output logic             busy,
    output ape_item_t        item
);

    logic [31:0] temp_q [0:1];
    logic        zero_q [0:1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy;
    // The back end never stalls, so the head leaves as soon as it is there.
    assign pop  = (count_reg != 2'd0);

    assign item.vld  = pop;
    assign item.temp = temp_q[rd_ptr_reg];
    assign item.zero = zero_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            temp_q[wr_ptr_reg] <= temperature;
            zero_q[wr_ptr_reg] <= (temperature == 32'd0);
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a transfer");

    // The head leaves every cycle, so the queue never fills.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("queue filled although the back end never stalls");

endmodule

`default_nettype wire

// ----- hw/rtl/ape_pow.sv -----
// Power term n*ln(T): log2 by repeated squaring, scaling to ln, product with n.
// Depends on ape_pkg.
`default_nettype none

module ape_pow
    import ape_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic [31:0]            temp,
    input  wire logic signed [31:0]     temp_exponent,
    output logic signed [NT_W-1:0]      nt
);

    localparam int LN_SH = 58 - FRAC_BITS;
    localparam int PM_SH = FRAC_BITS - 16;
    localparam logic signed [35:0] LN2_S = 36'(LN2_Q28);

    logic [4:0]          lead_c;
    logic [31:0]         x_reg  [0:LOG_FRAC];
    logic [LOG_FRAC-1:0] fr_reg [0:LOG_FRAC];
    logic [4:0]          p_reg  [0:LOG_FRAC];

    always_comb
    begin
        lead_c = 5'd0;
        for (int i = 0; i < 32; i++)
            if (temp[i])
                lead_c = 5'(i);
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]  <= temp << (5'd31 - lead_c);
        fr_reg[0] <= '0;
        p_reg[0]  <= lead_c;
    end

    // One squaring per stage yields one fraction bit of log2.
    for (genvar g = 0; g < LOG_FRAC; g++)
    begin : g_sq
        logic [63:0] sq;
        assign sq = 64'(x_reg[g]) * 64'(x_reg[g]);
        always_ff @(posedge clk)
        begin
            p_reg[g+1] <= p_reg[g];
            if (sq[63])
            begin
                x_reg[g+1]  <= sq[63:32];
                fr_reg[g+1] <= {fr_reg[g][LOG_FRAC-2:0], 1'b1};
            end
            else
            begin
                x_reg[g+1]  <= sq[62:31];
                fr_reg[g+1] <= {fr_reg[g][LOG_FRAC-2:0], 1'b0};
            end
        end
    end

    logic [57:0]        pa_reg;
    logic signed [35:0] pb_reg;
    logic signed [5:0]  pexp;
    logic signed [65:0] full;
    logic signed [31:0] lnt_reg;
    logic [31:0]        lm, nm;
    logic [47:0]        m1_reg, m2_reg;
    logic               neg_reg;
    logic [48:0]        psum;
    logic [40:0]        pm;

    assign pexp = $signed({1'b0, p_reg[LOG_FRAC]}) - 6'sd16;
    assign full = $signed({pb_reg, 30'b0}) + $signed({8'b0, pa_reg});
    assign lm   = lnt_reg[31] ? 32'(-lnt_reg) : 32'(lnt_reg);
    assign nm   = temp_exponent[31] ? 32'(-temp_exponent) : 32'(temp_exponent);
    assign psum = 49'(m1_reg) + 49'(m2_reg >> 16);
    assign pm   = 41'(psum >> PM_SH);

    always_ff @(posedge clk)
    begin
        pa_reg  <= 58'(fr_reg[LOG_FRAC]) * 58'(LN2_Q28);
        pb_reg  <= 36'(pexp) * LN2_S;
        lnt_reg <= 32'(full >>> LN_SH);
        m1_reg  <= 48'(lm[31:16]) * 48'(nm);
        m2_reg  <= 48'(lm[15:0]) * 48'(nm);
        neg_reg <= lnt_reg[31] ^ temp_exponent[31];
        nt      <= neg_reg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ape_div.sv -----
// Activation quotient Tact*2^DIV_SHIFT/T by restoring division, one bit a stage.
// Depends on ape_pkg.
`default_nettype none

module ape_div
    import ape_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic [31:0]          temp,
    input  wire logic [31:0]          act_temp,
    output logic [QUOT_BITS-1:0]      quot
);

    localparam int CAP_SH = CAP_LOG - DIV_SHIFT;
    localparam int REM_SH = QUOT_BITS - DIV_SHIFT;
    localparam logic [QUOT_BITS-1:0] CAP = QUOT_BITS'(1) << CAP_LOG;

    logic [31:0]          rem_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg    [0:QUOT_BITS];
    logic [31:0]          t_reg    [0:QUOT_BITS];
    logic [31:0]          tact_reg [0:QUOT_BITS];
    logic                 cap_reg  [0:QUOT_BITS];

    always_ff @(posedge clk)
    begin
        // Quotient reaches the cap exactly when Tact >= T * 2^CAP_SH.
        cap_reg[0]  <= (64'(act_temp) >= (64'(temp) << CAP_SH));
        rem_reg[0]  <= 32'(act_temp >> REM_SH);
        q_reg[0]    <= '0;
        t_reg[0]    <= temp;
        tact_reg[0] <= act_temp;
    end

    for (genvar g = 0; g < QUOT_BITS; g++)
    begin : g_bit
        localparam int BI = QUOT_BITS - 1 - g;
        logic        nb;
        logic [32:0] r2;
        if (BI >= DIV_SHIFT)
        begin : g_in
            assign nb = tact_reg[g][BI-DIV_SHIFT];
        end
        else
        begin : g_zero
            assign nb = 1'b0;
        end
        assign r2 = {rem_reg[g], nb};
        always_ff @(posedge clk)
        begin
            t_reg[g+1]    <= t_reg[g];
            tact_reg[g+1] <= tact_reg[g];
            cap_reg[g+1]  <= cap_reg[g];
            if (r2 >= {1'b0, t_reg[g]})
            begin
                rem_reg[g+1] <= 32'(r2 - {1'b0, t_reg[g]});
                q_reg[g+1]   <= {q_reg[g][QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg[g+1] <= r2[31:0];
                q_reg[g+1]   <= {q_reg[g][QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign quot = cap_reg[QUOT_BITS] ? CAP : q_reg[QUOT_BITS];

endmodule

`default_nettype wire

// ----- hw/rtl/ape_exp.sv -----
// Exponential stage: log to base two, then 2^r by a twelve-term Taylor series.
// Depends on ape_pkg.
`default_nettype none

module ape_exp
    import ape_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [31:0] lv_in,
    input  wire logic               err_in,
    output logic signed [31:0]      log_value,
    output logic signed [7:0]       exponent_two,
    output logic [23:0]             mantissa_fraction,
    output logic                    range_error
);

    typedef struct packed {
        logic [29:0]        z;
        logic [7:0]         e;
        logic               hi;
        logic               lo;
        logic signed [31:0] lv;
        logic               err;
        logic [32:0]        sum;
    } side_t;

    localparam logic signed [63:0] L2E = 64'(LOG2E_Q30);
    localparam logic [30:0] ONE = 31'd1 << 30;

    logic signed [63:0]    prod_reg;
    logic signed [31:0]    lv0_reg, lv1_reg;
    logic                  err0_reg, err1_reg;
    logic signed [63:0]    y, e_full;
    logic [FRAC_BITS-1:0]  r_reg;
    logic [7:0]            e_reg;
    logic                  hi_reg, lo_reg;

    assign y      = prod_reg >>> 30;
    assign e_full = y >>> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(lv_in) * L2E;
        lv0_reg  <= lv_in;
        err0_reg <= err_in;
        r_reg    <= y[FRAC_BITS-1:0];
        e_reg    <= e_full[7:0];
        hi_reg   <= (e_full > 64'sd127);
        lo_reg   <= (e_full < -64'sd128);
        lv1_reg  <= lv0_reg;
        err1_reg <= err0_reg;
    end

    side_t       sc_reg   [0:EXP_TERMS];
    logic [30:0] term_reg [0:EXP_TERMS];
    logic [53:0] zp;
    side_t       s0;

    assign zp = 54'(r_reg) * 54'(LN2_Q30);

    always_comb
    begin
        s0.z   = 30'(zp >> FRAC_BITS);
        s0.e   = e_reg;
        s0.hi  = hi_reg;
        s0.lo  = lo_reg;
        s0.lv  = lv1_reg;
        s0.err = err1_reg;
        s0.sum = 33'(ONE);
    end

    always_ff @(posedge clk)
    begin
        sc_reg[0]   <= s0;
        term_reg[0] <= ONE;
    end

    // Each term takes three stages: product with z, reciprocal multiply, correction.
    for (genvar k = 1; k <= EXP_TERMS; k++)
    begin : g_term
        localparam logic [32:0] RCP = recip(k);
        logic [61:0] tz;
        logic [63:0] tq;
        logic [30:0] va_reg, vb_reg, qa_reg, qk, q;
        side_t       sa_reg, sb_reg, sn;

        assign tz = 62'(term_reg[k-1]) * 62'(sc_reg[k-1].z);
        assign tq = 64'(va_reg) * 64'(RCP);
        assign qk = 31'(qa_reg * 31'(k));
        assign q  = ((vb_reg - qk) >= 31'(k)) ? qa_reg + 31'd1 : qa_reg;

        always_comb
        begin
            sn     = sb_reg;
            sn.sum = sb_reg.sum + 33'(q);
        end

        always_ff @(posedge clk)
        begin
            va_reg <= 31'(tz >> 30);
            sa_reg <= sc_reg[k-1];
            qa_reg <= 31'(tq >> 32);
            vb_reg <= va_reg;
            sb_reg <= sa_reg;
            term_reg[k] <= q;
            sc_reg[k]   <= sn;
        end
    end

    side_t       fin;
    logic [32:0] sat_sum;

    assign fin     = sc_reg[EXP_TERMS];
    assign sat_sum = (fin.sum >= (33'd1 << 31)) ? (33'd1 << 31) - 33'd1 : fin.sum;

    always_ff @(posedge clk)
    begin
        log_value <= fin.lv;
        if (fin.hi)
        begin
            exponent_two      <= 8'sd127;
            mantissa_fraction <= 24'hFFFFFF;
            range_error       <= 1'b1;
        end
        else if (fin.lo)
        begin
            exponent_two      <= -8'sd128;
            mantissa_fraction <= 24'd0;
            range_error       <= 1'b1;
        end
        else
        begin
            exponent_two      <= $signed(fin.e);
            mantissa_fraction <= 24'((sat_sum - 33'(ONE)) >> (30 - 24));
            range_error       <= fin.err;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/arrhenius_property_eval_unit.sv -----
// Top level of the Arrhenius property evaluator: configuration registers,
// front-end queue, power-term, division and exponential pipelines. Depends on ape_pkg.
`default_nettype none

// Channel      Direction  Handshake                 Payload
// input        in         start / busy              temperature
// result       out        result_valid (strobe)     log_value, exponent_two,
//                                                   mantissa_fraction, range_error
// config       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One temperature is taken every cycle; each result passes through the queue, the
// restoring divider (an input register and 41 bit stages), a register for the
// sum and clamp, and the exponential pipeline. The back end never stalls, so the
// two-entry queue holds at most one sample and busy stays low. Reset clears the
// configuration registers to zero and empties the queue and pipeline. The
// receiver cannot stall results.

module arrhenius_property_eval_unit
    import ape_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [31:0]        temperature,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    result_valid,
    output logic signed [31:0]      log_value,
    output logic signed [7:0]       exponent_two,
    output logic [23:0]             mantissa_fraction,
    output logic                    range_error
);

    // Configuration registers. Writes are taken at any time; the contract is
    // that they arrive only while no sample is in flight.
    logic signed [31:0] log_prefactor_reg;
    logic signed [31:0] temp_exponent_reg;
    logic [31:0]        activation_temp_reg;
    logic               viscosity_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_prefactor_reg   <= '0;
            temp_exponent_reg   <= '0;
            activation_temp_reg <= '0;
            viscosity_mode_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LOG_PREFACTOR:   log_prefactor_reg   <= $signed(cfg_data);
                REG_TEMP_EXPONENT:   temp_exponent_reg   <= $signed(cfg_data);
                REG_ACTIVATION_TEMP: activation_temp_reg <= cfg_data;
                REG_VISCOSITY_MODE:  viscosity_mode_reg  <= cfg_data[0];
                default:             viscosity_mode_reg  <= viscosity_mode_reg;
            endcase
        end
    end

    // Front end: transfer, zero-temperature classification and queue.
    ape_item_t item;

    ape_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .temperature (temperature),
        .busy        (busy),
        .item        (item)
    );

    // Back end: the power term and the quotient run side by side.
    logic signed [NT_W-1:0] nt;
    logic [QUOT_BITS-1:0]   quot;

    ape_pow u_pow (
        .clk           (clk),
        .temp          (item.temp),
        .temp_exponent (temp_exponent_reg),
        .nt            (nt)
    );

    ape_div u_div (
        .clk      (clk),
        .temp     (item.temp),
        .act_temp (activation_temp_reg),
        .quot     (quot)
    );

    // The power term is ready sooner than the quotient; delay it to match.
    localparam int NT_DLY = DIV_LAT - POW_LAT;
    logic signed [NT_W-1:0] nt_dly [0:NT_DLY-1];

    always_ff @(posedge clk)
    begin
        nt_dly[0] <= nt;
        for (int i = 1; i < NT_DLY; i++)
            nt_dly[i] <= nt_dly[i-1];
    end

    // Valid and zero flags follow each sample down the pipeline.
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [DIV_LAT-1:0]   zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], item.vld};
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= {zero_reg[DIV_LAT-2:0], item.zero};
    end

    // Sum of the three terms, clamped to the signed 32-bit range. A zero
    // temperature saturates towards the side that the mode selects.
    localparam logic signed [43:0] LV_MAX = 44'sh0007FFFFFFF;
    localparam logic signed [43:0] LV_MIN = -44'sh00080000000;

    logic signed [43:0] qs, lsum;
    logic signed [31:0] comb_lv_reg;
    logic               comb_err_reg;

    assign qs   = $signed({3'b0, quot});
    assign lsum = 44'(log_prefactor_reg) + 44'(nt_dly[NT_DLY-1])
                + (viscosity_mode_reg ? qs : -qs);

    always_ff @(posedge clk)
    begin
        if (zero_reg[DIV_LAT-1])
        begin
            comb_lv_reg  <= viscosity_mode_reg ? 32'sh7FFFFFFF : 32'sh80000000;
            comb_err_reg <= 1'b1;
        end
        else if (lsum > LV_MAX)
        begin
            comb_lv_reg  <= 32'sh7FFFFFFF;
            comb_err_reg <= 1'b1;
        end
        else if (lsum < LV_MIN)
        begin
            comb_lv_reg  <= 32'sh80000000;
            comb_err_reg <= 1'b1;
        end
        else
        begin
            comb_lv_reg  <= 32'(lsum);
            comb_err_reg <= 1'b0;
        end
    end

    ape_exp u_exp (
        .clk               (clk),
        .lv_in             (comb_lv_reg),
        .err_in            (comb_err_reg),
        .log_value         (log_value),
        .exponent_two      (exponent_two),
        .mantissa_fraction (mantissa_fraction),
        .range_error       (range_error)
    );

    assign result_valid = vld_reg[TOTAL_LAT-1];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(item.vld, TOTAL_LAT))
        else $error("result without a matching transfer");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_LAT-1] && zero_reg[DIV_LAT-1] |=> comb_err_reg)
        else $error("zero temperature did not raise the range flag");

    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_LAT-1] && zero_reg[DIV_LAT-1] |=>
        (comb_lv_reg == 32'sh7FFFFFFF || comb_lv_reg == 32'sh80000000))
        else $error("zero temperature log not saturated");

endmodule

`default_nettype wire

// ----- tb/tb_arrhenius_property_eval_unit.sv -----
// Self-checking testbench for arrhenius_property_eval_unit: directed table then random temperatures
// under several register settings, results checked against typed values or a behavioural predictor.
// Depends on ape_pkg (register index enum) and the RTL of the block.
`timescale 1ns / 100ps

module tb_arrhenius_property_eval_unit;
    import ape_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;

    // Fixed-point constants of the evaluator's arithmetic.
    localparam longint LN2_Q28_C   = 64'd186065279;
    localparam longint LN2_Q30_C   = 64'd744261118;
    localparam longint LOG2E_Q30_C = 64'd1549082005;
    localparam longint QUOT_CAP_C  = 64'd1 << 40;

    typedef struct {
        logic signed [31:0] log_v;
        logic signed [7:0]  exp2;
        logic [23:0]        frac;
        logic               err;
    } property_t;

    // One row of the directed table: register setting, temperature and,
    // where it is obvious, the expected result typed in.
    typedef struct {
        logic signed [31:0] lnA;
        logic signed [31:0] n;
        logic [31:0]        tact;
        logic               visc;
        logic [31:0]        temp;
        logic               typed;
        property_t          want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [31:0] temperature = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic result_valid;
    logic signed [31:0] log_value;
    logic signed [7:0] exponent_two;
    logic [23:0] mantissa_fraction;
    logic range_error;

    // Shadow copy of the configuration registers.
    logic signed [31:0] sh_lnA;
    logic signed [31:0] sh_n;
    logic [31:0]        sh_tact;
    logic               sh_visc;

    property_t pending_props[$];
    int fail_count = 0;
    int checked_count = 0;
    int sat_count = 0;
    int idle_pct = 0;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    arrhenius_property_eval_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .temperature(temperature), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .result_valid(result_valid),
        .log_value(log_value), .exponent_two(exponent_two),
        .mantissa_fraction(mantissa_fraction), .range_error(range_error)
    );

    // Natural log of a Q16.16 temperature in Q8.24, via a truncated log2 built
    // by repeated squaring of the normalised mantissa.
    function automatic longint ln_of_temp(input logic [31:0] t);
        int lead;
        longint unsigned x;
        longint frac_bits;
        longint l2;
        lead = 31;
        frac_bits = 0;
        while (lead > 0 && t[lead] == 1'b0)
            lead--;
        x = longint'(t) << (31 - lead);
        for (int i = 1; i <= 30; i++)
        begin
            x = x * x;
            if (x[63])
            begin
                frac_bits = frac_bits | (64'd1 << (30 - i));
                x = x >> 32;
            end
            else
                x = x >> 31;
        end
        l2 = (longint'(lead) - 16) * (64'sd1 <<< 30) + frac_bits;
        return (l2 * LN2_Q28_C) >>> 34;
    endfunction

    // Full evaluation of one temperature under the shadow configuration.
    function automatic property_t predict_property(input logic [31:0] t);
        property_t p;
        longint lnt, nt, sum, y, e;
        longint unsigned lm, nm, pm, q, rem, r, z, term, acc;
        logic neg;
        p.err = 1'b0;
        if (t == 0)
        begin
            p.err = 1'b1;
            p.log_v = sh_visc ? 32'sh7FFFFFFF : 32'sh80000000;
        end
        else
        begin
            lnt = ln_of_temp(t);
            lm = (lnt < 0) ? -lnt : lnt;
            nm = (sh_n < 0) ? -longint'(sh_n) : longint'(sh_n);
            pm = ((lm >> 16) * nm + (((lm & 64'hFFFF) * nm) >> 16)) >> 8;
            neg = (lnt < 0) != (sh_n < 0);
            nt = neg ? -longint'(pm) : longint'(pm);
            q = sh_tact / t;
            rem = sh_tact % t;
            // Restoring division for the remaining quotient bits, capped.
            for (int i = 0; i < 28; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= t)
                begin
                    rem = rem - t;
                    q = q | 64'd1;
                end
                if (q >= QUOT_CAP_C)
                begin
                    q = QUOT_CAP_C;
                    break;
                end
            end
            sum = longint'(sh_lnA) + nt + (sh_visc ? longint'(q) : -longint'(q));
            if (sum > 64'sd2147483647)
            begin
                sum = 64'sd2147483647;
                p.err = 1'b1;
            end
            else if (sum < -64'sd2147483648)
            begin
                sum = -64'sd2147483648;
                p.err = 1'b1;
            end
            p.log_v = sum[31:0];
        end
        y = (longint'(p.log_v) * LOG2E_Q30_C) >>> 30;
        e = y >>> 24;
        if (t == 0)
        begin
            p.exp2 = sh_visc ? 8'sd127 : -8'sd128;
            p.frac = sh_visc ? 24'hFFFFFF : 24'h0;
        end
        else if (e > 127)
        begin
            p.exp2 = 8'sd127;
            p.frac = 24'hFFFFFF;
            p.err = 1'b1;
        end
        else if (e < -128)
        begin
            p.exp2 = -8'sd128;
            p.frac = 24'h0;
            p.err = 1'b1;
        end
        else
        begin
            r = y & 64'hFFFFFF;
            z = (r * LN2_Q30_C) >> 24;
            term = 64'd1 << 30;
            acc = term;
            for (int k = 1; k <= 12; k++)
            begin
                term = ((term * z) >> 30) / k;
                acc = acc + term;
            end
            if (acc >= (64'd1 << 31))
                acc = (64'd1 << 31) - 1;
            p.exp2 = e[7:0];
            p.frac = 24'((acc - (64'd1 << 30)) >> 6);
        end
        return p;
    endfunction

    // Result monitor and watchdog; everything is sampled at the rising edge.
    always @(posedge clk)
    begin
        property_t w;
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            if (result_valid)
            begin
                if (pending_props.size() == 0)
                begin
                    $error("result transfer with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    w = pending_props.pop_front();
                    checked_count++;
                    if (w.err)
                        sat_count++;
                    if (log_value !== w.log_v)
                    begin
                        $error("log_value: expected %0d, got %0d", w.log_v, log_value);
                        fail_count++;
                    end
                    if (exponent_two !== w.exp2)
                    begin
                        $error("exponent_two: expected %0d, got %0d", w.exp2, exponent_two);
                        fail_count++;
                    end
                    if (mantissa_fraction !== w.frac)
                    begin
                        $error("mantissa_fraction: expected %h, got %h",
                               w.frac, mantissa_fraction);
                        fail_count++;
                    end
                    if (range_error !== w.err)
                    begin
                        $error("range_error: expected %0b, got %0b", w.err, range_error);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Offers one temperature, idling at random first, and records the
    // expectation once the transfer has happened.
    task automatic send_temp(input logic [31:0] t, input logic typed, input property_t want);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        temperature <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_props.insert(pending_props.size(), typed ? want : predict_property(t));
    endtask

    // Lets all results arrive, then a further pause before registers change.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_props.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_LOG_PREFACTOR:   sh_lnA = val;
            REG_TEMP_EXPONENT:   sh_n = val;
            REG_ACTIVATION_TEMP: sh_tact = val;
            REG_VISCOSITY_MODE:  sh_visc = val[0];
            default:             sh_visc = sh_visc;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic signed [31:0] a, input logic signed [31:0] n,
                              input logic [31:0] tact, input logic visc);
        if (a == sh_lnA && n == sh_n && tact == sh_tact && visc == sh_visc)
            return;
        wait_idle();
        write_reg(REG_LOG_PREFACTOR, a);
        write_reg(REG_TEMP_EXPONENT, n);
        write_reg(REG_ACTIVATION_TEMP, tact);
        write_reg(REG_VISCOSITY_MODE, {31'd0, visc});
    endtask

    // Mostly physical temperatures, with the odd tiny, huge or zero value.
    function automatic logic [31:0] random_temp();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return ($urandom_range(3000, 150) << 16) | $urandom_range(16'hFFFF);
        else if (sel < 75)
            return $urandom_range(1000);
        else if (sel < 78)
            return 32'd0;
        else
            return $urandom;
    endfunction

    initial
    begin
        row_t rows[$];
        property_t none;
        logic signed [31:0] a;
        logic signed [31:0] n;
        logic [31:0] tact;
        none = '{0, 0, 0, 0};
        sh_lnA = 0;
        sh_n = 0;
        sh_tact = 0;
        sh_visc = 0;

        // Directed table. The first rows run on the reset values of the registers.
        rows.insert(rows.size(), '{0, 0, 0, 0, 32'd0, 1, '{32'sh80000000, -8'sd128, 24'h0, 1}});
        rows.insert(rows.size(), '{0, 0, 0, 0, 32'h0001_0000, 1, '{0, 0, 24'h0, 0}});
        rows.insert(rows.size(), '{0, 0, 0, 0, 32'hFFFF_FFFF, 1, '{0, 0, 24'h0, 0}});
        rows.insert(rows.size(), '{0, 0, 0, 0, 32'd1, 1, '{0, 0, 24'h0, 0}});
        rows.insert(rows.size(), '{0, 0, 0, 1, 32'd0, 1,
                                   '{32'sh7FFFFFFF, 8'sd127, 24'hFFFFFF, 1}});
        // Activation term saturates the log high and the exponent overflows.
        rows.insert(rows.size(), '{32'sh7FFFFFFF, 0, 32'hFFFF_FFFF, 1, 32'd1, 1,
                                   '{32'sh7FFFFFFF, 8'sd127, 24'hFFFFFF, 1}});
        // Same from below: log clamps low and the exponent underflows.
        rows.insert(rows.size(), '{32'sh80000000, 0, 32'hFFFF_FFFF, 0, 32'd1, 1,
                                   '{32'sh80000000, -8'sd128, 24'h0, 1}});
        rows.insert(rows.size(), '{0, 32'sh7FFFFFFF, 0, 0, 32'hFFFF_FFFF, 0, none});
        rows.insert(rows.size(), '{0, 32'sh7FFFFFFF, 0, 0, 32'd1, 0, none});
        rows.insert(rows.size(), '{0, 32'sh80000000, 0, 0, 32'd1, 0, none});
        rows.insert(rows.size(), '{0, 32'sh80000000, 0, 0, 32'hFFFF_FFFF, 0, none});
        rows.insert(rows.size(), '{32'sh0100_0000, 0, 0, 0, 32'h0001_0000, 0, none});
        rows.insert(rows.size(), '{32'sh0100_0000, 32'sh0080_0000, 32'd300 << 12, 0,
                                   32'd300 << 16, 0, none});
        rows.insert(rows.size(), '{32'sh0100_0000, 32'sh0080_0000, 32'd300 << 12, 1,
                                   32'd300 << 16, 0, none});
        rows.insert(rows.size(), '{32'shF800_0000, -32'sh0180_0000, 32'd20000 << 12, 1,
                                   32'd1200 << 16, 0, none});
        rows.insert(rows.size(), '{32'shF800_0000, -32'sh0180_0000, 32'd20000 << 12, 1,
                                   32'd0, 0, none});
        rows.insert(rows.size(), '{32'h7FFF_FFFF, 32'sh7FFFFFFF, 32'hFFFF_FFFF, 0,
                                   32'h8000_0000, 0, none});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            set_config(rows[i].lnA, rows[i].n, rows[i].tact, rows[i].visc);
            send_temp(rows[i].temp, rows[i].typed, rows[i].want);
        end

        // Random part: three idling phases, each over three register settings.
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 27 : (ph == 1) ? 56 : 0;
            for (int s = 0; s < 3; s++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    a = $urandom;
                    n = $urandom;
                    tact = $urandom;
                end
                else
                begin
                    a = $signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
                    n = $signed($urandom_range(32'h0600_0000)) - 32'sh0300_0000;
                    tact = $urandom_range(30000 << 12);
                end
                set_config(a, n, tact, 1'($urandom_range(1)));
                for (int k = 0; k < 155; k++)
                begin
                    if (k % 40 == 39)
                    begin
                        @(negedge clk);
                        start <= 1'b0;
                        repeat ($urandom_range(30)) @(negedge clk);
                    end
                    send_temp(random_temp(), 1'b0, none);
                end
            end
        end

        wait_idle();
        $display("Checked %0d results (%0d flagged out of range) across directed extremes,",
                 checked_count, sat_count);
        $display("both activation conventions and nine random register settings.");
        if (fail_count == 0 && pending_props.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
